>>> sv/rvst_pkg.sv
// rvst_pkg: shared types and constants of the voice slot table
// holds operation and status codes, controller states and the slot entry layout
// no dependencies
package rvst_pkg;

   localparam int KEY_W   = 16;
   localparam int COUNT_W = 16;
   localparam int MASK_W  = 16;
   localparam int SLOT_W  = 4;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [2:0] {
      FUNC_START     = 3'd0,
      FUNC_STOP_KEY  = 3'd1,
      FUNC_STOP_SLOT = 3'd2,
      FUNC_TICK      = 3'd3,
      FUNC_CLEAR     = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      STATUS_DONE = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_NONE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY
   } state_type;

   typedef struct packed {
      logic               shared;
      logic [COUNT_W-1:0] count;
      logic [KEY_W-1:0]   sound_key;
      logic [KEY_W-1:0]   archive_key;
   } slot_entry_type;

endpackage

>>> sv/refcounted_voice_slot_table.sv
// refcounted_voice_slot_table: reference-counted voice slot table
// depends on rvst_pkg; slot entries live in one synchronous memory, live bits in flops
//
// start and stop by key scan the slot memory one entry per cycle through a registered read,
//   then go to the apply step; other operations go from accept straight to the apply step
// one item at a time: next beat is taken once the previous result is in the output register
// reset: synchronous, clears live and written bits, so every slot reads as all zero
module refcounted_voice_slot_table
   import rvst_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   // archive_key[15:0], sound_key[31:16], shared[32], slot_index[36:33],
   // playing_mask[52:37], zero pad[55:53]
   input  logic [55:0] req_tdata,
   // func[2:0]
   input  logic [2:0]  req_tuser,

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // result_slot[3:0], start_voice[4], stop_slot_voice[5], stop_by_keys[6],
   // active_mask[22:7], zero pad[23]
   output logic [23:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]  rsp_tuser
);

   localparam int IW = $clog2(SLOTS);
   localparam int CW = IW + 1;

   // slot memory: keys, count, shared flag; count is meaningful only while the live bit is set
   slot_entry_type mem [SLOTS];
   slot_entry_type rd_data_ff;
   logic [IW-1:0]  rd_addr;
   logic           mem_we;
   logic [IW-1:0]  mem_wa;
   slot_entry_type mem_wd;

   // live bit per slot and written bit per slot (entry written since reset)
   logic [SLOTS-1:0] active_ff, active_in;
   logic [SLOTS-1:0] written_ff, written_in;

   state_type state_ff, state_in;

   // latched request beat
   func_type            func_ff;
   logic [KEY_W-1:0]    akey_ff;
   logic [KEY_W-1:0]    skey_ff;
   logic                shared_ff;
   logic [SLOT_W-1:0]   sidx_ff;
   logic [MASK_W-1:0]   pmask_ff;

   // scan pipeline: issue pointer and the slot whose data sits in rd_data_ff
   logic [CW-1:0]  issue_ff, issue_in;
   logic           chk_valid_ff, chk_valid_in;
   logic [IW-1:0]  chk_idx_ff, chk_idx_in;

   // scan findings
   logic           found_hit_ff, found_hit_in;
   logic [IW-1:0]  hit_idx_ff, hit_idx_in;
   slot_entry_type hit_entry_ff, hit_entry_in;
   logic           hit_active_ff, hit_active_in;
   logic           found_free_ff, found_free_in;
   logic [IW-1:0]  free_idx_ff, free_idx_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic              rsp_start_ff, rsp_start_in;
   logic              rsp_stop_one_ff, rsp_stop_one_in;
   logic              rsp_stop_keys_ff, rsp_stop_keys_in;
   logic [MASK_W-1:0] rsp_mask_ff, rsp_mask_in;

   logic           req_fire;
   slot_entry_type chk_entry;
   logic           chk_active;
   logic           key_match;
   logic           scan_done;
   logic           slot_live;
   logic [COUNT_W-1:0] count_dec;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {1'b0, rsp_mask_ff, rsp_stop_keys_ff, rsp_stop_one_ff,
                        rsp_start_ff, rsp_slot_ff};

   // entry under check; a never-written slot reads as all zero
   assign chk_entry  = written_ff[chk_idx_ff] ? rd_data_ff : '0;
   assign chk_active = active_ff[chk_idx_ff];
   assign key_match  = (chk_entry.archive_key == akey_ff) && (chk_entry.sound_key == skey_ff);
   assign count_dec  = hit_entry_ff.count - COUNT_W'(1);

   always_comb begin
      state_in         = state_ff;
      active_in        = active_ff;
      written_in       = written_ff;
      issue_in         = issue_ff;
      chk_valid_in     = chk_valid_ff;
      chk_idx_in       = chk_idx_ff;
      found_hit_in     = found_hit_ff;
      hit_idx_in       = hit_idx_ff;
      hit_entry_in     = hit_entry_ff;
      hit_active_in    = hit_active_ff;
      found_free_in    = found_free_ff;
      free_idx_in      = free_idx_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_slot_in      = rsp_slot_ff;
      rsp_start_in     = rsp_start_ff;
      rsp_stop_one_in  = rsp_stop_one_ff;
      rsp_stop_keys_in = rsp_stop_keys_ff;
      rsp_mask_in      = rsp_mask_ff;
      rd_addr          = issue_ff[IW-1:0];
      mem_we           = 1'b0;
      mem_wa           = '0;
      mem_wd           = '0;
      scan_done        = 1'b0;
      slot_live        = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               issue_in      = '0;
               chk_valid_in  = 1'b0;
               found_hit_in  = 1'b0;
               found_free_in = 1'b0;
               if (func_type'(req_tuser) == FUNC_START ||
                   func_type'(req_tuser) == FUNC_STOP_KEY) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_APPLY;
               end
            end
         end

         ST_SCAN: begin
            // issue side: one read per cycle
            if (issue_ff < CW'(SLOTS)) begin
               chk_valid_in = 1'b1;
               chk_idx_in   = issue_ff[IW-1:0];
               issue_in     = issue_ff + CW'(1);
            end else begin
               chk_valid_in = 1'b0;
            end
            // check side: data read last cycle
            if (chk_valid_ff) begin
               if (func_ff == FUNC_START) begin
                  if (!chk_active) begin
                     if (!found_free_ff) begin
                        found_free_in = 1'b1;
                        free_idx_in   = chk_idx_ff;
                     end
                     // without sharing the first free slot ends the search
                     if (!shared_ff) begin
                        scan_done = 1'b1;
                     end
                  end else if (shared_ff && chk_entry.shared && key_match) begin
                     found_hit_in  = 1'b1;
                     hit_idx_in    = chk_idx_ff;
                     hit_entry_in  = chk_entry;
                     hit_active_in = 1'b1;
                     scan_done     = 1'b1;
                  end
               end else if (key_match) begin
                  // stop by key: stale entries match too
                  found_hit_in  = 1'b1;
                  hit_idx_in    = chk_idx_ff;
                  hit_entry_in  = chk_entry;
                  hit_active_in = chk_active;
                  scan_done     = 1'b1;
               end
               if (chk_idx_ff == IW'(SLOTS - 1)) begin
                  scan_done = 1'b1;
               end
            end
            if (scan_done) begin
               state_in = ST_APPLY;
            end
         end

         ST_APPLY: begin
            // write-back, live bit update and result load together in the same cycle
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in     = 1'b1;
               rsp_status_in    = STATUS_DONE;
               rsp_slot_in      = '0;
               rsp_start_in     = 1'b0;
               rsp_stop_one_in  = 1'b0;
               rsp_stop_keys_in = 1'b0;
               state_in         = ST_IDLE;

               case (func_ff)
                  FUNC_START: begin
                     if (found_hit_ff) begin
                        // reuse a shared slot, saturating count
                        mem_we       = 1'b1;
                        mem_wa       = hit_idx_ff;
                        mem_wd       = hit_entry_ff;
                        mem_wd.count = (hit_entry_ff.count == COUNT_MAX) ?
                                       COUNT_MAX : hit_entry_ff.count + COUNT_W'(1);
                        rsp_slot_in  = SLOT_W'(hit_idx_ff);
                     end else if (!found_free_ff) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        mem_we                  = 1'b1;
                        mem_wa                  = free_idx_ff;
                        mem_wd.archive_key      = akey_ff;
                        mem_wd.sound_key        = skey_ff;
                        mem_wd.count            = COUNT_W'(1);
                        mem_wd.shared           = shared_ff;
                        written_in[free_idx_ff] = 1'b1;
                        active_in[free_idx_ff]  = 1'b1;
                        rsp_slot_in             = SLOT_W'(free_idx_ff);
                        rsp_start_in            = 1'b1;
                     end
                  end

                  FUNC_STOP_KEY: begin
                     if (!found_hit_ff) begin
                        rsp_status_in = STATUS_NONE;
                     end else begin
                        rsp_slot_in = SLOT_W'(hit_idx_ff);
                        if (hit_active_ff) begin
                           mem_we       = 1'b1;
                           mem_wa       = hit_idx_ff;
                           mem_wd       = hit_entry_ff;
                           mem_wd.count = count_dec;
                           if (count_dec == '0) begin
                              mem_wd.shared          = 1'b0;
                              active_in[hit_idx_ff]  = 1'b0;
                              rsp_stop_keys_in       = 1'b1;
                           end
                        end
                     end
                  end

                  FUNC_STOP_SLOT: begin
                     rsp_slot_in = sidx_ff;
                     for (int i = 0; i < SLOTS; i++) begin
                        if (i == int'(sidx_ff) && active_ff[i]) begin
                           slot_live    = 1'b1;
                           active_in[i] = 1'b0;
                        end
                     end
                     if (slot_live) begin
                        rsp_stop_one_in = 1'b1;
                     end else begin
                        rsp_status_in = STATUS_NONE;
                     end
                  end

                  FUNC_TICK: begin
                     // slots without a mask bit count as not playing
                     active_in = active_ff & SLOTS'(pmask_ff);
                  end

                  FUNC_CLEAR: begin
                     active_in = '0;
                  end

                  default: begin
                     rsp_status_in = STATUS_NONE;
                  end
               endcase

               rsp_mask_in = MASK_W'(active_in);
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         active_ff     <= '0;
         written_ff    <= '0;
         issue_ff      <= '0;
         chk_valid_ff  <= 1'b0;
         found_hit_ff  <= 1'b0;
         found_free_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         written_ff    <= written_in;
         issue_ff      <= issue_in;
         chk_valid_ff  <= chk_valid_in;
         found_hit_ff  <= found_hit_in;
         found_free_ff <= found_free_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         func_ff   <= func_type'(req_tuser);
         akey_ff   <= req_tdata[15:0];
         skey_ff   <= req_tdata[31:16];
         shared_ff <= req_tdata[32];
         sidx_ff   <= req_tdata[36:33];
         pmask_ff  <= req_tdata[52:37];
      end
      chk_idx_ff       <= chk_idx_in;
      hit_idx_ff       <= hit_idx_in;
      hit_entry_ff     <= hit_entry_in;
      hit_active_ff    <= hit_active_in;
      free_idx_ff      <= free_idx_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_slot_ff      <= rsp_slot_in;
      rsp_start_ff     <= rsp_start_in;
      rsp_stop_one_ff  <= rsp_stop_one_in;
      rsp_stop_keys_ff <= rsp_stop_keys_in;
      rsp_mask_ff      <= rsp_mask_in;
   end

   // slot memory; writes happen only after the scan, so no read overlaps a pending write
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // at most one voice command per result
   a_one_command: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({rsp_start_ff, rsp_stop_one_ff, rsp_stop_keys_ff}))
      else $error("more than one voice command in a result");

   // a failed operation issues no command
   a_fail_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STATUS_DONE) |->
         !(rsp_start_ff || rsp_stop_one_ff || rsp_stop_keys_ff))
      else $error("command issued with failing status");

   // a live slot was always written at least once
   a_live_written: assert property (@(posedge clock) disable iff (reset)
      (active_ff & ~written_ff) == '0)
      else $error("live slot never written");

   // memory is written only in the write-back cycle
   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_APPLY))
      else $error("slot memory written outside write-back");

   // an accepted beat always starts work
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != ST_IDLE))
      else $error("accepted beat dropped");

endmodule
